### sv/idp_pkg.sv
// Package for the id pool ring allocator: item structs, status and operation codes,
// register indexes and reset constants. Depends on nothing.
package idp_pkg;

  localparam int DEF_POOL_DEPTH = 1024;
  localparam int ID_W           = 16;

  localparam logic [ID_W-1:0] MIN_ID_RESET = 16'd0;
  localparam logic [ID_W-1:0] MAX_ID_RESET = 16'd1023;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_REINIT  = 2'd2;

  localparam logic [1:0] CFG_MIN_ID = 2'd0;
  localparam logic [1:0] CFG_MAX_ID = 2'd1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_FULL   = 3'd3,
    ST_BADCFG = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FILL
  } state_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] release_id;
  } req_t;

  typedef struct packed {
    logic            ok;
    status_t         status;
    logic [ID_W-1:0] granted_id;
  } rsp_t;

  typedef struct packed {
    logic [1:0]      reg_index;
    logic [ID_W-1:0] reg_value;
  } cfg_t;

endpackage

### sv/idp_chan_if.sv
// Valid/ready channel interface carrying one payload struct per item.
// Payload type is a parameter; structs come from idp_pkg.
interface idp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/idp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module idp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/id_pool_ring_allocator_top.sv
// Top level of the id pool ring allocator: control, ring pointers and fill sequencer.
// Depends on idp_pkg, idp_chan_if and idp_ram.
//
// Usage: req carries one item {operation, release_id}; rsp returns one item
// {ok, status, granted_id} per request, in order; cfg writes min_id (index 0)
// and max_id (index 1) and is always ready. Write cfg only while the pool idles.
// Free ids live in a RAM of POOL_DEPTH+1 entries used as a circular list.
// Release and failed operations answer in the cycle after acceptance;
// a successful allocate first passes S_READ, where the registered RAM read returns the id.
// A good reinit walks the RAM writing one id per cycle and answers when the walk
// is done; req is held off during the walk.
// Throughput: one release request every cycle while rsp takes each result; an
// allocate holds req off in S_READ while the single registered read port of the ring RAM returns the id.
// Reset (synchronous, active high) starts the same fill with min_id 0 and
// max_id 1023, with req not ready and no response. If POOL_DEPTH is
// below 1024 the pool comes up empty instead, with range 0..0.
// A stalled rsp holds the result in the output register; req is held off
// until rsp drains.
module id_pool_ring_allocator_top
  import idp_pkg::*;
#(
  parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
  input logic       clk,
  input logic       rst,
  idp_chan_if.sink   req,
  idp_chan_if.sink   cfg,
  idp_chan_if.source rsp
);

  localparam int RING_DEPTH = POOL_DEPTH + 1;
  localparam int PW         = $clog2(RING_DEPTH);
  localparam int SW         = $clog2(POOL_DEPTH + 2);
  localparam int RST_COUNT  = int'(MAX_ID_RESET) - int'(MIN_ID_RESET) + 1;
  localparam bit RESET_OK   = (MIN_ID_RESET < MAX_ID_RESET) && (RST_COUNT <= POOL_DEPTH);

  localparam logic [PW-1:0]   RST_FRONT = RESET_OK ? PW'(RST_COUNT) : '0;
  localparam logic [PW-1:0]   RST_LAST  = RESET_OK ? PW'(RST_COUNT - 1) : '0;
  localparam logic [SW-1:0]   RST_SIZE  = RESET_OK ? SW'(RST_COUNT + 1) : SW'(1);
  localparam logic [ID_W-1:0] RST_AMIN  = RESET_OK ? MIN_ID_RESET : '0;
  localparam logic [ID_W-1:0] RST_AMAX  = RESET_OK ? MAX_ID_RESET : '0;

  state_t          state, state_next;
  logic [PW-1:0]   front_pos, front_pos_next;
  logic [PW-1:0]   back_pos, back_pos_next;
  logic [SW-1:0]   ring_size, ring_size_next;
  logic [ID_W-1:0] active_min, active_min_next;
  logic [ID_W-1:0] active_max, active_max_next;
  logic [ID_W-1:0] fill_min, fill_min_next;
  logic [PW-1:0]   fill_cnt, fill_cnt_next;
  logic [PW-1:0]   fill_last, fill_last_next;
  logic            fill_report, fill_report_next;
  logic [ID_W-1:0] min_id, max_id;
  logic            out_valid, out_valid_next;
  rsp_t            out_data, out_data_next;

  logic            in_fire;
  logic            ring_empty;
  logic            ring_full;
  logic            id_in_range;
  logic [ID_W-1:0] id_span;
  logic            cfg_good;
  logic [PW-1:0]   new_count;
  logic            fill_done;

  logic            ram_we;
  logic [PW-1:0]   ram_waddr;
  logic [ID_W-1:0] ram_wdata;
  logic [ID_W-1:0] ram_rdata;

  function automatic logic [PW-1:0] step_pos(input logic [PW-1:0] p,
                                             input logic [SW-1:0] size);
    logic [SW-1:0] n;
    n = SW'(p) + SW'(1);
    return (n >= size) ? '0 : PW'(n);
  endfunction

  assign in_fire     = req.valid && req.ready;
  assign ring_empty  = (front_pos == back_pos);
  assign ring_full   = (step_pos(front_pos, ring_size) == back_pos);
  assign id_in_range = (req.data.release_id >= active_min) &&
                       (req.data.release_id <= active_max);
  assign id_span     = max_id - min_id;
  assign cfg_good    = (min_id < max_id) && (32'(id_span) < 32'(POOL_DEPTH));
  assign new_count   = PW'(id_span) + PW'(1);
  assign fill_done   = (fill_cnt == fill_last);

  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_id <= MIN_ID_RESET;
      max_id <= MAX_ID_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.reg_index)
        CFG_MIN_ID: min_id <= cfg.data.reg_value;
        CFG_MAX_ID: max_id <= cfg.data.reg_value;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (req.data.operation)
            OP_ALLOC:   if (!ring_empty) state_next = S_READ;
            OP_RELEASE: state_next = S_IDLE;
            default:    if (cfg_good) state_next = S_FILL;
          endcase
        end
      end
      S_READ: state_next = S_IDLE;
      S_FILL: if (fill_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and RAM port control
  always_comb begin
    req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
    ram_we    = 1'b0;
    ram_waddr = front_pos;
    ram_wdata = req.data.release_id;
    unique case (state)
      S_IDLE: begin
        ram_we = in_fire && (req.data.operation == OP_RELEASE) && id_in_range && !ring_full;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_cnt;
        ram_wdata = fill_min + ID_W'(fill_cnt);
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    front_pos_next   = front_pos;
    back_pos_next    = back_pos;
    ring_size_next   = ring_size;
    active_min_next  = active_min;
    active_max_next  = active_max;
    fill_min_next    = fill_min;
    fill_cnt_next    = fill_cnt;
    fill_last_next   = fill_last;
    fill_report_next = fill_report;
    out_data_next    = out_data;
    out_valid_next   = out_valid && !rsp.ready;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          out_data_next = '{ok: 1'b0, status: ST_OK, granted_id: '0};
          unique case (req.data.operation)
            OP_ALLOC: begin
              if (ring_empty) begin
                out_data_next.status = ST_EMPTY;
                out_valid_next       = 1'b1;
              end else begin
                // granted id arrives from the RAM next cycle
                back_pos_next = step_pos(back_pos, ring_size);
              end
            end
            OP_RELEASE: begin
              out_valid_next = 1'b1;
              if (!id_in_range) begin
                out_data_next.status = ST_RANGE;
              end else if (ring_full) begin
                out_data_next.status = ST_FULL;
              end else begin
                out_data_next.ok = 1'b1;
                front_pos_next   = step_pos(front_pos, ring_size);
              end
            end
            default: begin
              if (!cfg_good) begin
                out_data_next.status = ST_BADCFG;
                out_valid_next       = 1'b1;
              end else begin
                front_pos_next   = new_count;
                back_pos_next    = '0;
                ring_size_next   = SW'(new_count) + SW'(1);
                active_min_next  = min_id;
                active_max_next  = max_id;
                fill_min_next    = min_id;
                fill_cnt_next    = '0;
                fill_last_next   = new_count - PW'(1);
                fill_report_next = 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        out_data_next  = '{ok: 1'b1, status: ST_OK, granted_id: ram_rdata};
        out_valid_next = 1'b1;
      end
      S_FILL: begin
        fill_cnt_next = fill_cnt + PW'(1);
        if (fill_done && fill_report) begin
          out_data_next  = '{ok: 1'b1, status: ST_OK, granted_id: '0};
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= RESET_OK ? S_FILL : S_IDLE;
      front_pos   <= RST_FRONT;
      back_pos    <= '0;
      ring_size   <= RST_SIZE;
      active_min  <= RST_AMIN;
      active_max  <= RST_AMAX;
      fill_min    <= MIN_ID_RESET;
      fill_cnt    <= '0;
      fill_last   <= RST_LAST;
      fill_report <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front_pos   <= front_pos_next;
      back_pos    <= back_pos_next;
      ring_size   <= ring_size_next;
      active_min  <= active_min_next;
      active_max  <= active_max_next;
      fill_min    <= fill_min_next;
      fill_cnt    <= fill_cnt_next;
      fill_last   <= fill_last_next;
      fill_report <= fill_report_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

  idp_ram #(
    .WIDTH(ID_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(back_pos),
    .rdata(ram_rdata)
  );

`ifndef SYNTHESIS
  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    (SW'(front_pos) < ring_size) && (SW'(back_pos) < ring_size))
    else $error("ring position beyond ring size");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.ok) |-> (out_data.granted_id == '0))
    else $error("granted id nonzero on failed operation");

  a_alloc_answers: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (req.data.operation == OP_ALLOC) && !ring_empty) |->
      ##2 (rsp.valid && rsp.data.ok))
    else $error("allocate from nonempty pool did not answer");
`endif

endmodule

### tb/tb.sv
// Testbench for id_pool_ring_allocator_top: drives allocate, release and reinit
// items and checks each response against a behavioral model of the free-id ring.
// Depends on idp_pkg, idp_chan_if and the RTL of the allocator.
module tb
  import idp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_DEPTH   = DEF_POOL_DEPTH;
  localparam int STALL_LIMIT  = 6000;
  localparam int RANDOM_ITEMS = 1425;

  // operation code with both bits set, decoded as reinit
  localparam logic [1:0] OP_REINIT_ALT = 2'd3;

  // traffic modes; roll_idle gives each its idle percentages: sender, receiver
  localparam int MODE_SLOW_SINK = 0;
  localparam int MODE_SLOW_SRC  = 1;
  localparam int MODE_FULL_RATE = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  idp_chan_if #(.T(req_t)) req_if ();
  idp_chan_if #(.T(cfg_t)) cfg_if ();
  idp_chan_if #(.T(rsp_t)) rsp_if ();

  id_pool_ring_allocator_top #(.POOL_DEPTH(POOL_DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .cfg (cfg_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // model of the pool
  logic [ID_W-1:0] free_ring [0:POOL_DEPTH];
  int unsigned     front_pos, back_pos, ring_len;
  int unsigned     act_min, act_max;
  int unsigned     reg_min, reg_max;

  req_t        pending_reqs [$];
  rsp_t        expected_rsps [$];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  int unsigned traffic_mode = MODE_SLOW_SINK;

  // range the stimulus aims releases at
  int unsigned gen_lo, gen_hi;

  // register values as last written by the stimulus
  int unsigned gen_reg_min = MIN_ID_RESET;
  int unsigned gen_reg_max = MAX_ID_RESET;

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= ring_len) ? 0 : p + 1;
  endfunction

  function automatic bit config_good(int unsigned lo, int unsigned hi);
    return (lo < hi) && (hi - lo + 1 <= POOL_DEPTH);
  endfunction

  // refill the ring from the registers; leave everything as is on a bad range
  function automatic bit pool_refill();
    int unsigned count;
    if (!config_good(reg_min, reg_max))
      return 1'b0;
    count    = reg_max - reg_min + 1;
    ring_len = count + 1;
    act_min  = reg_min;
    act_max  = reg_max;
    for (int unsigned i = 0; i < count; i++)
      free_ring[i] = ID_W'(reg_min + i);
    free_ring[count] = '0;
    front_pos = count;
    back_pos  = 0;
    return 1'b1;
  endfunction

  function automatic rsp_t pool_step(req_t it);
    rsp_t r;
    r.ok         = 1'b0;
    r.status     = ST_OK;
    r.granted_id = '0;
    if (it.operation == OP_ALLOC) begin
      if (front_pos == back_pos) begin
        r.status = ST_EMPTY;
      end else begin
        r.granted_id = free_ring[back_pos];
        back_pos     = ring_next(back_pos);
        r.ok         = 1'b1;
      end
    end else if (it.operation == OP_RELEASE) begin
      if (it.release_id < act_min || it.release_id > act_max) begin
        r.status = ST_RANGE;
      end else if (ring_next(front_pos) == back_pos) begin
        r.status = ST_FULL;
      end else begin
        free_ring[front_pos] = it.release_id;
        front_pos            = ring_next(front_pos);
        r.ok                 = 1'b1;
      end
    end else begin
      // high operation bit set: reinit
      if (pool_refill())
        r.ok = 1'b1;
      else
        r.status = ST_BADCFG;
    end
    return r;
  endfunction

  function automatic bit roll_idle(bit sender);
    int unsigned pct;
    case (traffic_mode)
      MODE_SLOW_SINK: pct = sender ? 12 : 68;
      MODE_SLOW_SRC:  pct = sender ? 68 : 12;
      default:        pct = 0;
    endcase
    return $urandom_range(99, 0) < pct;
  endfunction

  // driver and response sink
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && !roll_idle(1'b1)) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= !roll_idle(1'b0);
    end
  end

  // monitor: check responses, then predict for newly accepted items
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          fail_count++;
        end else begin
          rsp_t want;
          want = expected_rsps.pop_front();
          if (rsp_if.data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, rsp_if.data.ok);
            fail_count++;
          end
          if (rsp_if.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_if.data.status);
            fail_count++;
          end
          if (rsp_if.data.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0d, got %0d",
                   want.granted_id, rsp_if.data.granted_id);
            fail_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready)
        expected_rsps.insert(expected_rsps.size(), pool_step(req_if.data));
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.data.reg_index == CFG_MIN_ID)
          reg_min = cfg_if.data.reg_value;
        else if (cfg_if.data.reg_index == CFG_MAX_ID)
          reg_max = cfg_if.data.reg_value;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(logic [1:0] op, logic [ID_W-1:0] rid);
    req_t it;
    it.operation  = op;
    it.release_id = rid;
    pending_reqs.insert(pending_reqs.size(), it);
    // track the range a good reinit latches
    if (op[1] && config_good(gen_reg_min, gen_reg_max)) begin
      gen_lo = gen_reg_min;
      gen_hi = gen_reg_max;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [ID_W-1:0] val);
    cfg_t c;
    c.reg_index = idx;
    c.reg_value = val;
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_range(int unsigned lo, int unsigned hi);
    wait_drained();
    write_reg(CFG_MIN_ID, ID_W'(lo));
    write_reg(CFG_MAX_ID, ID_W'(hi));
    gen_reg_min = lo;
    gen_reg_max = hi;
    @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] pick_release_id();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 80)
      return ID_W'($urandom_range(gen_hi, gen_lo));
    if (r < 90) begin
      if (gen_lo > 0 && ($urandom_range(1, 0) == 0 || gen_hi == 65535))
        return ID_W'(gen_lo - 1);
      if (gen_hi < 65535)
        return ID_W'(gen_hi + 1);
    end
    return ID_W'($urandom());
  endfunction

  task automatic random_phase(int unsigned n_items);
    int unsigned r, count, lo, hi, alloc_pct;
    r = $urandom_range(99, 0);
    if (r < 4) begin
      lo = $urandom_range(65535, 0);
      hi = lo;
    end else if (r < 7) begin
      lo = $urandom_range(65535, 1);
      hi = $urandom_range(lo - 1, 0);
    end else if (r < 9) begin
      lo = $urandom_range(65535 - POOL_DEPTH, 0);
      hi = $urandom_range(65535, lo + POOL_DEPTH);
    end else begin
      if (r < 12)
        count = $urandom_range(POOL_DEPTH, POOL_DEPTH / 2);
      else if (r < 30)
        count = $urandom_range(80, 17);
      else
        count = $urandom_range(16, 2);
      lo = $urandom_range(65536 - count, 0);
      hi = lo + count - 1;
    end
    set_range(lo, hi);
    push_item($urandom_range(1, 0) ? OP_REINIT : OP_REINIT_ALT, ID_W'($urandom()));
    case ($urandom_range(2, 0))
      0:       alloc_pct = 25;
      1:       alloc_pct = 50;
      default: alloc_pct = 75;
    endcase
    for (int unsigned i = 1; i < n_items; i++) begin
      r = $urandom_range(99, 0);
      if (r < 3)
        push_item($urandom_range(1, 0) ? OP_REINIT : OP_REINIT_ALT, ID_W'($urandom()));
      else if ($urandom_range(99, 0) < alloc_pct)
        push_item(OP_ALLOC, ID_W'($urandom()));
      else
        push_item(OP_RELEASE, pick_release_id());
      // hold the sender until the pool has answered everything
      if (i == n_items / 2 && $urandom_range(3, 0) == 0)
        wait_drained();
    end
  endtask

  initial begin
    int unsigned sent;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    reg_min   = MIN_ID_RESET;
    reg_max   = MAX_ID_RESET;
    ring_len  = 1;
    act_min   = 0;
    act_max   = 0;
    front_pos = 0;
    back_pos  = 0;
    void'(pool_refill());
    gen_lo = MIN_ID_RESET;
    gen_hi = MAX_ID_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default range: allocate, out of range above max_id, fill to full
    push_item(OP_ALLOC, 16'd0);
    push_item(OP_ALLOC, 16'hFFFF);
    push_item(OP_RELEASE, 16'd1023);
    push_item(OP_RELEASE, 16'd1024);
    push_item(OP_RELEASE, 16'd0);
    push_item(OP_RELEASE, 16'd0);
    push_item(OP_RELEASE, 16'hFFFF);
    push_item(OP_RELEASE, 16'd5);

    // two ids at the top of the space: drain to empty, refill to full
    set_range(65534, 65535);
    push_item(OP_REINIT, 16'd0);
    push_item(OP_ALLOC, 16'd0);
    push_item(OP_ALLOC, 16'd0);
    push_item(OP_ALLOC, 16'd0);
    push_item(OP_RELEASE, 16'd65533);
    push_item(OP_RELEASE, 16'd65535);
    push_item(OP_RELEASE, 16'd65534);
    push_item(OP_RELEASE, 16'd65535);
    push_item(OP_REINIT_ALT, 16'hFFFF);

    // bad ranges keep the pool as it is
    set_range(7, 7);
    push_item(OP_REINIT, 16'd0);
    push_item(OP_ALLOC, 16'd0);
    set_range(9, 3);
    push_item(OP_REINIT, 16'd0);
    set_range(0, POOL_DEPTH);
    push_item(OP_REINIT_ALT, 16'd0);
    set_range(0, 65535);
    push_item(OP_REINIT, 16'd0);

    // largest pool that fits
    set_range(65536 - POOL_DEPTH, 65535);
    push_item(OP_REINIT, 16'd0);
    push_item(OP_ALLOC, 16'd0);
    push_item(OP_RELEASE, 16'd0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      int unsigned n;
      if (sent < RANDOM_ITEMS / 3)
        traffic_mode = MODE_SLOW_SINK;
      else if (sent < 2 * RANDOM_ITEMS / 3)
        traffic_mode = MODE_SLOW_SRC;
      else
        traffic_mode = MODE_FULL_RATE;
      n = $urandom_range(60, 20);
      random_phase(n);
      sent += n;
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
